/* src/nibble_frame_checker_macros.svh */
// Assertion macros for the nibble frame checker
`ifndef NIBBLE_FRAME_CHECKER_MACROS_SVH
`define NIBBLE_FRAME_CHECKER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define NFC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nibble_frame_checker: assertion failed");

// next-cycle implication, disabled in reset
`define NFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nibble_frame_checker: assertion failed");

`else

`define NFC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define NFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* src/nfc_pkg.sv */
// Types and constants for the nibble frame checker
package nfc_pkg;

    localparam int BYTE_W      = 8;
    localparam int NIB_W       = 4;
    localparam int STATUS_W    = 2;
    localparam int CLASS_W     = 3;
    localparam int NUM_CODES   = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int OUT_FIELD_W = BYTE_W + STATUS_W + CLASS_W + BYTE_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0]  START_MARK  = 8'hAA;
    localparam logic [BYTE_W-1:0]  END_MARK    = 8'hBB;
    localparam logic [NIB_W-1:0]   NIBBLE_MASK = 4'hF;
    localparam logic [CLASS_W-1:0] CLASS_NONE  = 3'd6;
    localparam logic [CLASS_W-1:0] CLASS_ZERO  = 3'd0;

    typedef enum logic [1:0] {
        POS_START   = 2'd0,
        POS_REQ     = 2'd1,
        POS_PAYLOAD = 2'd2
    } t_pos;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FRAME = 2'd1,
        ST_CSUM  = 2'd2
    } t_status;

    typedef enum logic {
        KIND_BYTE    = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

endpackage

/* src/nibble_frame_checker.sv */
// Nibble frame checker: delimiter, pairing and additive checksum check of command frames
//
// Input beats on s_axis carry one raw frame byte in tdata[7:0]; tlast marks the
// closing byte. Every beat is taken into an input register, then one pass of
// logic updates the frame state and, where the beat completes a nibble pair or
// ends the frame, loads a result beat into the output register on m_axis.
// tuser tells a decoded byte (0) from an end-of-frame verdict (1).
// Each accepted input beat passes the input register and then the output
// register before its result is valid on m_axis. Throughput: one beat per
// cycle while m_axis is free; a stalled m_axis holds its beat while s_axis
// takes one more beat into the input register and then holds tready low until
// m_axis moves.
// Configuration: i_cfg_we writes request code i_cfg_idx (0 .. 5) with
// i_cfg_data; indexes 6 and 7 are ignored. Write only while
// idle. Reset (synchronous, active low) empties both registers, returns the
// checker to awaiting a frame start and loads the codes 0 through 5.
`include "nibble_frame_checker_macros.svh"

module nibble_frame_checker
    import nfc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [BYTE_W-1:0]         s_axis_tdata,  // raw_byte
    input  logic                      s_axis_tlast,  // frame_end
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // decoded_byte, status, request_class, request_code, zero fill
    output logic [OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                      m_axis_tuser,  // result_kind
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [BYTE_W-1:0]         i_cfg_data
);

    logic [BYTE_W-1:0] r_codes [NUM_CODES];

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    t_pos              r_pos, n_pos;
    logic              r_start_good, n_start_good;
    logic              r_pair_half, n_pair_half;
    logic [NIB_W-1:0]  r_high_nib, n_high_nib;
    logic [BYTE_W-1:0] r_req, n_req;
    logic [BYTE_W-1:0] r_last_item, n_last_item;
    logic [BYTE_W-1:0] r_sum, n_sum;

    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [BYTE_W-1:0]  r_out_dec;
    t_status            r_out_status;
    logic [CLASS_W-1:0] r_out_class;
    logic [BYTE_W-1:0]  r_out_code;

    logic               emit;
    t_kind              n_kind;
    logic [BYTE_W-1:0]  n_dec;
    t_status            n_status;
    logic [CLASS_W-1:0] n_class;
    logic [BYTE_W-1:0]  n_code;
    logic [CLASS_W-1:0] req_class;
    logic               adv;
    logic               proc;

    assign adv           = !r_out_valid || m_axis_tready;
    assign proc          = adv && r_in_valid;
    assign s_axis_tready = !r_in_valid || adv;

    // classify request, first matching code wins
    always_comb begin
        req_class = CLASS_NONE;
        for (int k = NUM_CODES - 1; k >= 0; k--) begin
            if (r_codes[k] == r_req) begin
                req_class = CLASS_W'(k);
            end
        end
    end

    // next frame position
    always_comb begin
        n_pos = r_pos;
        if (r_in_last) begin
            n_pos = POS_START;
        end else begin
            unique case (r_pos)
                POS_START:   n_pos = POS_REQ;
                POS_REQ:     n_pos = POS_PAYLOAD;
                POS_PAYLOAD: n_pos = POS_PAYLOAD;
                default:     n_pos = POS_START;
            endcase
        end
    end

    // frame state and result beat
    always_comb begin
        n_start_good = r_start_good;
        n_pair_half  = r_pair_half;
        n_high_nib   = r_high_nib;
        n_req        = r_req;
        n_last_item  = r_last_item;
        n_sum        = r_sum;
        emit         = 1'b0;
        n_kind       = KIND_VERDICT;
        n_dec        = '0;
        n_status     = ST_FRAME;
        unique case (r_pos)
            POS_START: begin
                n_start_good = (r_in_byte == START_MARK);
                n_req        = '0;
                n_pair_half  = 1'b0;
                emit         = r_in_last;
            end
            POS_REQ: begin
                n_req        = r_in_byte;
                n_last_item  = r_in_byte;
                n_sum        = '0;
                n_pair_half  = 1'b0;
                emit         = r_in_last;
            end
            POS_PAYLOAD: begin
                if (r_in_last) begin
                    emit        = 1'b1;
                    n_pair_half = 1'b0;
                    priority if (!r_start_good || r_in_byte != END_MARK) begin
                        n_status = ST_FRAME;
                    end else if (r_sum != r_last_item) begin
                        n_status = ST_CSUM;
                    end else begin
                        n_status = ST_OK;
                    end
                end else if (!r_pair_half) begin
                    n_high_nib  = r_in_byte[NIB_W-1:0] & NIBBLE_MASK;
                    n_pair_half = 1'b1;
                end else begin
                    emit        = 1'b1;
                    n_pair_half = 1'b0;
                    n_kind      = KIND_BYTE;
                    n_status    = ST_OK;
                    n_dec       = {r_high_nib, r_in_byte[NIB_W-1:0] & NIBBLE_MASK};
                    n_sum       = BYTE_W'(r_sum + r_last_item);
                    n_last_item = n_dec;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        n_code = n_req;
        if (n_kind == KIND_BYTE) begin
            n_class = CLASS_ZERO;
        end else if (n_status == ST_OK) begin
            n_class = req_class;
        end else begin
            n_class = CLASS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CODES; k++) begin
                r_codes[k] <= BYTE_W'(k);
            end
        end else if (i_cfg_we && (int'(i_cfg_idx) < NUM_CODES)) begin
            r_codes[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= POS_START;
            r_start_good <= 1'b0;
            r_pair_half  <= 1'b0;
            r_high_nib   <= '0;
            r_req        <= '0;
            r_last_item  <= '0;
            r_sum        <= '0;
        end else if (proc) begin
            r_pos        <= n_pos;
            r_start_good <= n_start_good;
            r_pair_half  <= n_pair_half;
            r_high_nib   <= n_high_nib;
            r_req        <= n_req;
            r_last_item  <= n_last_item;
            r_sum        <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && emit) begin
            r_out_kind   <= n_kind;
            r_out_dec    <= n_dec;
            r_out_status <= n_status;
            r_out_class  <= n_class;
            r_out_code   <= n_code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = OUT_DATA_W'({r_out_code, r_out_class, r_out_status, r_out_dec});

    `NFC_ASSERT_NOW(a_err_class_none, i_clk, i_rst_n,
        r_out_valid && r_out_kind == KIND_VERDICT && r_out_status != ST_OK,
        r_out_class == CLASS_NONE && r_out_dec == '0)
    `NFC_ASSERT_NOW(a_byte_fields, i_clk, i_rst_n,
        r_out_valid && r_out_kind == KIND_BYTE,
        r_out_status == ST_OK && r_out_class == CLASS_ZERO)
    `NFC_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n,
        proc && r_in_last, r_pos == POS_START && !r_pair_half)
    `NFC_ASSERT_NEXT(a_last_gives_verdict, i_clk, i_rst_n,
        proc && r_in_last, r_out_valid && r_out_kind == KIND_VERDICT)

endmodule
